// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/bsort_pkg.sv -----
`timescale 1ns / 1ps

package bsort_pkg;

    // Block geometry
    localparam int BLOCK_SIZE = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(BLOCK_SIZE);
    localparam int LOG_N      = IDX_W;
    localparam int LVL_W      = $clog2(LOG_N + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [LVL_W-1:0]         lvl_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_shift;   // shift a new element in at the top
        logic sort_step;    // run one compare-exchange column
        logic emit_shift;   // move the bottom element to the output register
        lvl_t merge_log;    // log2 of the merge size of this column
        lvl_t stride_log;   // log2 of the compare stride of this column
    } bsort_cmd_t;

endpackage

// ----- rtl/core/bsort_datapath.sv -----
`timescale 1ns / 1ps

module bsort_datapath
    import bsort_pkg::*;
(
    input  logic       clk,
    input  bsort_cmd_t cmd,
    input  logic       ascending,
    input  data_t      data_value,
    output data_t      sorted_value
);

    data_t elem_reg  [BLOCK_SIZE];
    data_t elem_next [BLOCK_SIZE];
    data_t sorted_lane [BLOCK_SIZE];
    data_t out_value_reg;
    data_t out_value_next;

    // One column of the bitonic network: every lane compares with its partner
    always_comb
    begin
        idx_t  pos;
        idx_t  stride_mask;
        idx_t  merge_mask;
        idx_t  partner;
        logic  low_side;
        logic  up;
        logic  low_gt_high;
        logic  swap;
        data_t mine;
        data_t other;
        for (int i = 0; i < BLOCK_SIZE; i++)
        begin
            pos         = idx_t'(i);
            stride_mask = idx_t'(1) << cmd.stride_log;
            merge_mask  = idx_t'(1) << cmd.merge_log;
            partner     = pos ^ stride_mask;
            low_side    = ((pos & stride_mask) == '0);
            mine        = elem_reg[i];
            other       = elem_reg[partner];
            // final merge follows the register, inner merges alternate by segment
            if (cmd.merge_log == lvl_t'(LOG_N))
                up = ascending;
            else
                up = ((pos & merge_mask) == '0);
            low_gt_high = low_side ? (mine > other) : (other > mine);
            swap        = up ? low_gt_high
                             : (low_side ? (other > mine) : (mine > other));
            sorted_lane[i] = swap ? other : mine;
        end
    end

    // Select the next buffer contents and output value
    always_comb
    begin
        elem_next      = elem_reg;
        out_value_next = out_value_reg;
        if (cmd.load_shift)
        begin
            for (int i = 0; i < BLOCK_SIZE - 1; i++)
                elem_next[i] = elem_reg[i + 1];
            elem_next[BLOCK_SIZE-1] = data_value;
        end
        else if (cmd.sort_step)
        begin
            elem_next = sorted_lane;
        end
        else if (cmd.emit_shift)
        begin
            out_value_next = elem_reg[0];
            for (int i = 0; i < BLOCK_SIZE - 1; i++)
                elem_next[i] = elem_reg[i + 1];
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        elem_reg      <= elem_next;
        out_value_reg <= out_value_next;
    end

    assign sorted_value = out_value_reg;

endmodule

// ----- rtl/core/bsort_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsort_ctrl
    import bsort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       last_of_block,
    output bsort_cmd_t cmd
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam idx_t LAST_IDX = idx_t'(BLOCK_SIZE - 1);
    localparam lvl_t TOP_LVL  = lvl_t'(LOG_N);

    logic [1:0] state_reg, state_next;
    idx_t       count_reg, count_next;
    lvl_t       merge_reg, merge_next;
    lvl_t       stride_reg, stride_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_last_reg, out_last_next;
    logic       in_xfer;
    logic       out_load;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Sequence load, sort columns and emit
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        merge_next     = merge_reg;
        stride_next    = stride_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        cmd            = '0;
        cmd.merge_log  = merge_reg;
        cmd.stride_log = stride_reg;

        // drop the output once taken
        if (out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    cmd.load_shift = 1'b1;
                    if (count_reg == LAST_IDX)
                    begin
                        state_next  = ST_SORT;
                        count_next  = '0;
                        merge_next  = lvl_t'(1);
                        stride_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + idx_t'(1);
                    end
                end
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                if (stride_reg == '0)
                begin
                    if (merge_reg == TOP_LVL)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        merge_next  = merge_reg + lvl_t'(1);
                        stride_next = merge_reg;
                    end
                end
                else
                begin
                    stride_next = stride_reg - lvl_t'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    cmd.emit_shift = 1'b1;
                    out_valid_next = 1'b1;
                    out_last_next  = (count_reg == LAST_IDX);
                    if (count_reg == LAST_IDX)
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + idx_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                count_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            merge_reg     <= lvl_t'(1);
            stride_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            merge_reg     <= merge_next;
            stride_reg    <= stride_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign last_of_block = out_last_reg;

    `ASSERT_IMPLY(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load_shift, cmd.sort_step, cmd.emit_shift}))
    `ASSERT_IMPLY(a_stride_in_merge, clk, rst_n, state_reg == ST_SORT, stride_reg < merge_reg)
    `ASSERT_NEXT(a_block_full_sorts, clk, rst_n, in_xfer && count_reg == LAST_IDX, state_reg == ST_SORT && merge_reg == lvl_t'(1) && stride_reg == '0)
    `ASSERT_NEXT(a_last_flag, clk, rst_n, cmd.emit_shift && count_reg == LAST_IDX, state_reg == ST_LOAD && out_valid_reg && out_last_reg)

endmodule

// ----- rtl/core/bitonic_sorter_unit.sv -----
`timescale 1ns / 1ps
// Bitonic block sorter.
// Input channel (in_valid/in_ready, data_value): a block is exactly BLOCK_SIZE
// signed 32-bit values, one per transfer; in_ready is high while loading, so
// loading takes one cycle per value.
// Once the last value of a block is taken, the compare-exchange network runs
// one column per cycle, LOG_N*(LOG_N+1)/2 columns (10 for 16 elements), with
// all lanes of a column compared in parallel. Input is held off meanwhile.
// Output channel (out_valid/out_ready, sorted_value, last_of_block): the block
// leaves in sorted order through an output register, one value per cycle when
// the receiver is ready; last_of_block marks the final value. After the last
// column the controller enters the emit state and loads the first value into
// the output register. A stalled receiver holds the output register and
// pauses the emit; input is accepted again as soon as the last value sits in
// the output register.
// Configuration (cfg_valid/cfg_ready, ascending): always ready; 1 sorts
// smallest first, 0 largest first; read by every column of the final merge.
// Reset: empty block, output invalid, ascending = 1.

module bitonic_sorter_unit
    import bsort_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  data_t data_value,
    output logic  out_valid,
    input  logic  out_ready,
    output data_t sorted_value,
    output logic  last_of_block,
    input  logic  cfg_valid,
    output logic  cfg_ready,
    input  logic  ascending
);

    bsort_cmd_t cmd;
    logic       ascending_reg, ascending_next;

    // Direction register
    assign cfg_ready      = 1'b1;
    assign ascending_next = (cfg_valid && cfg_ready) ? ascending : ascending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ascending_reg <= 1'b1;
        else
            ascending_reg <= ascending_next;
    end

    bsort_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .last_of_block (last_of_block),
        .cmd           (cmd)
    );

    bsort_datapath u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .ascending    (ascending_reg),
        .data_value   (data_value),
        .sorted_value (sorted_value)
    );

endmodule
